// ----- rtl/command_timeout_wheel_tracker_macros.svh -----
// ----------------------------------------------------------------------------
// Command timeout wheel tracker: assertion macros
// Concurrent checks clocked on clk and disabled during rst; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef COMMAND_TIMEOUT_WHEEL_TRACKER_MACROS_SVH
`define COMMAND_TIMEOUT_WHEEL_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define CTWT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ctwt: concurrent check failed");
`define CTWT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ctwt: next-cycle check failed");
`else
`define CTWT_ASSERT(lbl, prop)
`define CTWT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/ctwt_pkg.sv -----
// ----------------------------------------------------------------------------
// Command timeout wheel tracker: package
// Field widths, command and register codes, result and state types.
// ----------------------------------------------------------------------------
package ctwt_pkg;

  localparam int CTWT_NUM_TAGS    = 32;
  localparam int CTWT_WHEEL_SLOTS = 64;

  localparam int CMD_W     = 3;
  localparam int TAG_W     = 5;
  localparam int STATUS_W  = 8;
  localparam int TICKS_W   = 20;
  localparam int CFG_IDX_W = 1;
  localparam int S_DATA_W  = 16;
  localparam int M_DATA_W  = 16;

  localparam logic [CMD_W-1:0] CMD_OPEN         = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WAIT_BACKEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_COMPLETE     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BACKEND_DONE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DRIVER_DONE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK         = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_STATUS = 1'd1;

  localparam logic KIND_RESPONSE = 1'b0;
  localparam logic KIND_RELEASE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_EX,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic                kind;
    logic [TAG_W-1:0]    tag;
    logic [STATUS_W-1:0] status;
    logic                timed;
  } res_t;

endpackage

// ----- rtl/command_timeout_wheel_tracker.sv -----
// ----------------------------------------------------------------------------
// Command timeout wheel tracker
// Command table with a hashed timing wheel; expiries reported in tag order.
// ----------------------------------------------------------------------------
// A command passes through the read, update and flush states before the block
// is ready again; its last result is loaded into the output register in flush.
// A tick walks the whole table entry by entry, reading and then updating each.
// Writing timeout_ticks runs the divider; the block is not ready until it is done.
// Stalls on the output side hold the update or flush state. Reset clears the
// per-entry valid bits; no clearing pass is needed.
module command_timeout_wheel_tracker
  import ctwt_pkg::*;
#(
  parameter int NUM_TAGS    = CTWT_NUM_TAGS,
  parameter int WHEEL_SLOTS = CTWT_WHEEL_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [CMD_W-1:0]     s_tuser,   // [2:0] cmd
  input  logic [S_DATA_W-1:0]  s_tdata,   // [4:0] tag, [12:5] status, [15:13] zero
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,   // [4:0] resp_tag, [12:5] resp_status,
                                          // [13] timed_out, [15:14] zero
  output logic                 m_tuser,   // [0] kind
  output logic                 m_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [TICKS_W-1:0]   cfg_data
);

`include "command_timeout_wheel_tracker_macros.svh"

  localparam int SLOT_W = $clog2(WHEEL_SLOTS);
  localparam int IDX_W  = $clog2(NUM_TAGS);

  typedef struct packed {
    logic               bd;
    logic               dd;
    logic               rs;
    logic               wt;
    logic               armed;
    logic [SLOT_W-1:0]  slot;
    logic [TICKS_W-1:0] rounds;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  state_t              state, state_next;
  logic [CMD_W-1:0]    cmd_q;
  logic [STATUS_W-1:0] status_q;
  logic [IDX_W-1:0]    idx;
  logic [SLOT_W-1:0]   cur_slot;
  logic [STATUS_W-1:0] tsc;
  logic [NUM_TAGS-1:0] valid;
  logic                pend_v;
  res_t                pend;
  logic                out_v;
  res_t                out_res;
  logic                out_last;

  logic [TAG_W-1:0]    in_tag;
  logic                in_acc;
  logic                tag_ok;
  logic                cmd_known;
  logic                last_idx;

  logic                div_start;
  logic [TICKS_W-1:0]  div_dividend;
  logic                div_busy;
  logic [TICKS_W-1:0]  div_quo;
  logic [SLOT_W-1:0]   div_rem;

  logic [ENTRY_W-1:0]  ram_rdata;
  logic                ram_we;
  entry_t              cur, upd;
  logic [SLOT_W:0]     slot_sum;
  logic [SLOT_W-1:0]   arm_slot;
  logic                has_resp, has_rel;
  res_t                resp, rel, first;
  logic                need_out, out_free, stall;

  logic                out_load, out_load_last, pend_load, pend_clr;
  res_t                out_load_res, pend_load_res;

  assign in_tag    = s_tdata[TAG_W-1:0];
  assign s_tready  = (state == ST_IDLE) && !cfg_we;
  assign in_acc    = s_tvalid && s_tready;
  assign tag_ok    = 32'(in_tag) < NUM_TAGS;
  assign cmd_known = s_tuser inside {CMD_OPEN, CMD_WAIT_BACKEND, CMD_COMPLETE,
                                     CMD_BACKEND_DONE, CMD_DRIVER_DONE};
  assign last_idx  = idx == IDX_W'(NUM_TAGS - 1);

  // Rounds and slot offset follow from timeout_ticks, so they are computed once
  // per register write; a zero timeout behaves as one tick.
  assign div_start    = cfg_we && (cfg_addr == REG_TIMEOUT_TICKS);
  assign div_dividend = (cfg_data == '0) ? '0 : cfg_data - 1'b1;

  ctwt_divider #(
    .DIVISOR    (WHEEL_SLOTS),
    .DIVIDEND_W (TICKS_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  ctwt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_TAGS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (upd),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // Entry update for the command held in cmd_q.
  always_comb begin
    cur         = valid[idx] ? entry_t'(ram_rdata) : '0;
    upd         = cur;
    has_resp    = 1'b0;
    has_rel     = 1'b0;
    resp        = '0;
    resp.kind   = KIND_RESPONSE;
    resp.tag    = TAG_W'(idx);
    rel         = '0;
    rel.kind    = KIND_RELEASE;
    rel.tag     = TAG_W'(idx);
    slot_sum    = (SLOT_W + 1)'(cur_slot) + (SLOT_W + 1)'(div_rem) + 1'b1;
    arm_slot    = (slot_sum >= (SLOT_W + 1)'(WHEEL_SLOTS))
                ? SLOT_W'(slot_sum - (SLOT_W + 1)'(WHEEL_SLOTS)) : SLOT_W'(slot_sum);
    unique case (cmd_q)
      CMD_TICK: begin
        if (cur.armed && (cur.slot == cur_slot)) begin
          if (cur.bd || cur.rs || !cur.wt) begin
            upd.armed = 1'b0;
          end else if (cur.rounds != '0) begin
            upd.rounds = cur.rounds - 1'b1;
          end else begin
            upd.rs      = 1'b1;
            upd.wt      = 1'b0;
            upd.armed   = 1'b0;
            has_resp    = 1'b1;
            resp.status = tsc;
            resp.timed  = 1'b1;
          end
        end
      end
      CMD_OPEN: begin
        upd    = '0;
        upd.bd = 1'b1;
      end
      CMD_WAIT_BACKEND: begin
        upd.wt = 1'b1;
        upd.bd = 1'b0;
        if (!cur.armed) begin
          upd.slot   = arm_slot;
          upd.rounds = div_quo;
          upd.armed  = 1'b1;
        end
      end
      CMD_COMPLETE: begin
        if (!cur.rs) begin
          upd.rs      = 1'b1;
          upd.wt      = 1'b0;
          has_resp    = 1'b1;
          resp.status = status_q;
        end
      end
      CMD_BACKEND_DONE: begin
        upd.armed = 1'b0;
        if (!cur.bd) begin
          upd.bd = 1'b1;
          if (!cur.rs) begin
            upd.rs      = 1'b1;
            upd.wt      = 1'b0;
            has_resp    = 1'b1;
            resp.status = status_q;
          end
          if (cur.dd) begin
            upd     = '0;
            has_rel = 1'b1;
          end
        end
      end
      CMD_DRIVER_DONE: begin
        upd.dd    = 1'b1;
        upd.armed = 1'b0;
        if (cur.bd) begin
          upd     = '0;
          has_rel = 1'b1;
        end
      end
      default: begin
      end
    endcase
    first = has_resp ? resp : rel;
  end

  // A new result goes to the pending register; the one it displaces goes out.
  // The pending result gets tlast when the transaction's work ends.
  assign out_free = !out_v || m_tready;
  assign need_out = (has_resp && has_rel) || ((has_resp || has_rel) && pend_v);
  assign stall    = need_out && !out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (div_start) begin
          state_next = ST_DIV;
        end else if (in_acc && ((s_tuser == CMD_TICK) || (cmd_known && tag_ok))) begin
          state_next = ST_RD;
        end
      end
      ST_DIV: begin
        if (!div_busy && !div_start) begin
          state_next = ST_IDLE;
        end
      end
      ST_RD: begin
        state_next = ST_EX;
      end
      ST_EX: begin
        if (!stall) begin
          state_next = ((cmd_q == CMD_TICK) && !last_idx) ? ST_RD : ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_v || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_we        = 1'b0;
    out_load      = 1'b0;
    out_load_res  = pend;
    out_load_last = 1'b0;
    pend_load     = 1'b0;
    pend_load_res = first;
    pend_clr      = 1'b0;
    unique case (state)
      ST_EX: begin
        if (!stall) begin
          ram_we = 1'b1;
          if (has_resp && has_rel) begin
            out_load      = 1'b1;
            out_load_res  = first;
            pend_load     = 1'b1;
            pend_load_res = rel;
          end else if (has_resp || has_rel) begin
            pend_load = 1'b1;
            out_load  = pend_v;
          end
        end
      end
      ST_FLUSH: begin
        if (pend_v && out_free) begin
          out_load      = 1'b1;
          out_load_last = 1'b1;
          pend_clr      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur_slot <= '0;
      tsc      <= STATUS_W'(1);
      valid    <= '0;
      pend_v   <= 1'b0;
      out_v    <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc && (s_tuser == CMD_TICK)) begin
        cur_slot <= (cur_slot == SLOT_W'(WHEEL_SLOTS - 1)) ? '0 : cur_slot + 1'b1;
      end
      if (cfg_we && (cfg_addr == REG_TIMEOUT_STATUS)) begin
        tsc <= cfg_data[STATUS_W-1:0];
      end
      if (ram_we) begin
        valid[idx] <= 1'b1;
      end
      if (pend_load) begin
        pend_v <= 1'b1;
      end else if (pend_clr) begin
        pend_v <= 1'b0;
      end
      if (out_load) begin
        out_v <= 1'b1;
      end else if (m_tready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_q    <= s_tuser;
      status_q <= s_tdata[TAG_W +: STATUS_W];
      idx      <= (s_tuser == CMD_TICK) ? '0 : IDX_W'(in_tag);
    end else if ((state == ST_EX) && !stall && (cmd_q == CMD_TICK) && !last_idx) begin
      idx <= idx + 1'b1;
    end
    if (pend_load) begin
      pend <= pend_load_res;
    end
    if (out_load) begin
      out_res  <= out_load_res;
      out_last <= out_load_last;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = M_DATA_W'({out_res.timed, out_res.status, out_res.tag});
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_last;

  `CTWT_ASSERT(a_idle_no_pending, (state == ST_IDLE) |-> !pend_v)
  `CTWT_ASSERT(a_two_results_empty_pending, (state == ST_EX && has_resp && has_rel) |-> !pend_v)
  `CTWT_ASSERT_NEXT(a_tick_moves_wheel, in_acc && (s_tuser == CMD_TICK), cur_slot != $past(cur_slot))

endmodule

// ----- rtl/ctwt_ram.sv -----
// ----------------------------------------------------------------------------
// Command timeout wheel tracker: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ctwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ctwt_divider.sv -----
// ----------------------------------------------------------------------------
// Command timeout wheel tracker: constant divisor unit
// Division by a fixed divisor through a reciprocal multiplication: the
// quotient is registered on start, the remainder is registered from it while busy.
// ----------------------------------------------------------------------------
module ctwt_divider #(
  parameter int DIVISOR    = 64,
  parameter int DIVIDEND_W = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DIVIDEND_W-1:0]      dividend,
  output logic                       busy,
  output logic [DIVIDEND_W-1:0]      quotient,
  output logic [$clog2(DIVISOR)-1:0] remainder
);

  localparam int REM_W  = $clog2(DIVISOR);
  localparam int SHIFT  = DIVIDEND_W + REM_W;
  localparam int PROD_W = SHIFT + DIVIDEND_W;
  // Rounded-up reciprocal; exact for every dividend below 2**DIVIDEND_W.
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic [DIVIDEND_W-1:0] held;
  logic [PROD_W-1:0]     prod;
  logic [DIVIDEND_W-1:0] back;
  logic [DIVIDEND_W-1:0] diff;

  always_comb begin
    prod = PROD_W'(dividend) * PROD_W'(RECIP);
    back = quotient * DIVIDEND_W'(DIVISOR);
    diff = held - back;
  end

  // Quotient and remainder reset to the result for a zero dividend.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      held      <= '0;
      quotient  <= '0;
      remainder <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      held     <= dividend;
      quotient <= prod[SHIFT +: DIVIDEND_W];
    end else if (busy) begin
      remainder <= diff[REM_W-1:0];
      busy      <= 1'b0;
    end
  end

endmodule
